### rtl/pcsc_pkg.sv
// Package for the PNG chunk stream checker.
// Holds the item structs, status and phase codes, and stream constants.
// No dependencies.
package pcsc_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SIGNATURE = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_BAD_IHDR  = 3'd3,
        ST_ZERO_SIZE = 3'd4,
        ST_CRC       = 3'd5,
        ST_IEND_LEN  = 3'd6,
        ST_TRUNCATED = 3'd7
    } status_t;

    typedef enum logic [12:0] {
        PH_SIG       = 13'b0000000000001,
        PH_IHDR_LEN  = 13'b0000000000010,
        PH_IHDR_TYPE = 13'b0000000000100,
        PH_IHDR_W    = 13'b0000000001000,
        PH_IHDR_H    = 13'b0000000010000,
        PH_IHDR_REST = 13'b0000000100000,
        PH_IHDR_CRC  = 13'b0000001000000,
        PH_CH_LEN    = 13'b0000010000000,
        PH_CH_TYPE   = 13'b0000100000000,
        PH_CH_DATA   = 13'b0001000000000,
        PH_CH_CRC    = 13'b0010000000000,
        PH_IEND_CRC  = 13'b0100000000000,
        PH_DONE      = 13'b1000000000000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_mark;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [30:0] image_width;
        logic [30:0] image_height;
    } out_item_t;

    // first signature byte in the top byte
    localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;

    localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] TYPE_IHDR  = 32'h49484452;
    localparam logic [31:0] TYPE_IEND  = 32'h49454E44;
    localparam logic [31:0] IHDR_LEN   = 32'd13;

endpackage

### rtl/pcsc_crc32_byte.sv
// One-byte update of the reflected CRC-32 register.
// Depends on pcsc_pkg for the polynomial.
module pcsc_crc32_byte
    import pcsc_pkg::*;
(
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [31:0] crc_out
);

    always_comb begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data_in};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        crc_out = c;
    end

endmodule

### rtl/png_chunk_stream_checker.sv
// Top level of the PNG chunk stream checker: input register, parser state, result register.
// Depends on pcsc_pkg and pcsc_crc32_byte.
//
// Takes a PNG file one byte per item and gives one verdict per file (status, and the IHDR
// width and height when the status is ok). It accepts one item every cycle unless a verdict
// waits untaken in the result register. The rate is set by the parser step between the
// input register and the result register, whose longest path is the one-byte CRC-32
// update. An end-mark item before a verdict gives a truncated status; after a verdict,
// bytes are dropped until the end mark, which rearms the parser silently.
module png_chunk_stream_checker
    import pcsc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // input register
    logic     in_valid_reg, in_valid_next;
    in_item_t in_data_reg;

    // output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [30:0] byte_count_reg, byte_count_next;
    logic [31:0] running_crc_reg, running_crc_next;
    logic [31:0] field_shift_reg, field_shift_next;
    logic [31:0] current_type_reg, current_type_next;
    logic [30:0] saved_width_reg, saved_width_next;
    logic [30:0] saved_height_reg, saved_height_next;
    logic        verdict_given_reg, verdict_given_next;

    logic        proceed;
    logic [7:0]  b;
    logic [31:0] crc_upd;
    logic [31:0] fs_new;
    logic [31:0] type_new;
    logic        cnt3;
    logic [30:0] cnt_inc;
    logic [30:0] cnt_dec;
    logic        give_en;
    status_t     give_status;

    assign proceed = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proceed;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign b        = in_data_reg.data_byte;
    assign fs_new   = {field_shift_reg[23:0], b};
    assign type_new = {current_type_reg[23:0], b};
    assign cnt3     = (byte_count_reg == 31'd3);
    assign cnt_inc  = byte_count_reg + 31'd1;
    assign cnt_dec  = byte_count_reg - 31'd1;

    pcsc_crc32_byte u_crc (
        .crc_in  (running_crc_reg),
        .data_in (b),
        .crc_out (crc_upd)
    );

    always_comb begin
        phase_next         = phase_reg;
        byte_count_next    = byte_count_reg;
        running_crc_next   = running_crc_reg;
        field_shift_next   = field_shift_reg;
        current_type_next  = current_type_reg;
        saved_width_next   = saved_width_reg;
        saved_height_next  = saved_height_reg;
        verdict_given_next = verdict_given_reg;
        give_en            = 1'b0;
        give_status        = ST_OK;

        if (in_data_reg.end_mark) begin
            if (!verdict_given_reg) begin
                give_en     = 1'b1;
                give_status = ST_TRUNCATED;
            end
            phase_next         = PH_SIG;
            byte_count_next    = '0;
            running_crc_next   = CRC_PRESET;
            field_shift_next   = '0;
            current_type_next  = '0;
            saved_width_next   = '0;
            saved_height_next  = '0;
            verdict_given_next = 1'b0;
        end else if (!verdict_given_reg) begin
            case (phase_reg)
                PH_SIG: begin
                    if (b != PNG_MAGIC[{~byte_count_reg[2:0], 3'b000} +: 8]) begin
                        give_en     = 1'b1;
                        give_status = ST_SIGNATURE;
                    end else if (byte_count_reg >= 31'd7) begin
                        byte_count_next = '0;
                        phase_next      = PH_IHDR_LEN;
                    end else begin
                        byte_count_next = cnt_inc;
                    end
                end
                PH_IHDR_LEN, PH_CH_LEN: begin
                    field_shift_next = fs_new;
                    byte_count_next  = cnt3 ? 31'd0 : cnt_inc;
                    if (cnt3) begin
                        if (fs_new[31]) begin
                            give_en     = 1'b1;
                            give_status = ST_OVERFLOW;
                        end else begin
                            running_crc_next = CRC_PRESET;
                            phase_next = (phase_reg == PH_IHDR_LEN) ? PH_IHDR_TYPE : PH_CH_TYPE;
                        end
                    end
                end
                PH_IHDR_TYPE: begin
                    running_crc_next  = crc_upd;
                    current_type_next = type_new;
                    byte_count_next   = cnt3 ? 31'd0 : cnt_inc;
                    if (cnt3) begin
                        if (field_shift_reg != IHDR_LEN || type_new != TYPE_IHDR) begin
                            give_en     = 1'b1;
                            give_status = ST_BAD_IHDR;
                        end else begin
                            phase_next = PH_IHDR_W;
                        end
                    end
                end
                PH_IHDR_W, PH_IHDR_H: begin
                    running_crc_next = crc_upd;
                    field_shift_next = fs_new;
                    byte_count_next  = cnt3 ? 31'd0 : cnt_inc;
                    if (cnt3) begin
                        if (fs_new[31]) begin
                            give_en     = 1'b1;
                            give_status = ST_OVERFLOW;
                        end else if (fs_new == 32'd0) begin
                            give_en     = 1'b1;
                            give_status = ST_ZERO_SIZE;
                        end else if (phase_reg == PH_IHDR_W) begin
                            saved_width_next = fs_new[30:0];
                            phase_next       = PH_IHDR_H;
                        end else begin
                            saved_height_next = fs_new[30:0];
                            phase_next        = PH_IHDR_REST;
                        end
                    end
                end
                PH_IHDR_REST: begin
                    // depth, color type, compression, filter, interlace
                    running_crc_next = crc_upd;
                    if (byte_count_reg >= 31'd4) begin
                        byte_count_next = '0;
                        phase_next      = PH_IHDR_CRC;
                    end else begin
                        byte_count_next = cnt_inc;
                    end
                end
                PH_IHDR_CRC, PH_CH_CRC: begin
                    field_shift_next = fs_new;
                    byte_count_next  = cnt3 ? 31'd0 : cnt_inc;
                    if (cnt3) begin
                        if (fs_new != ~running_crc_reg) begin
                            give_en     = 1'b1;
                            give_status = ST_CRC;
                        end else begin
                            phase_next = PH_CH_LEN;
                        end
                    end
                end
                PH_CH_TYPE: begin
                    running_crc_next  = crc_upd;
                    current_type_next = type_new;
                    byte_count_next   = cnt3 ? 31'd0 : cnt_inc;
                    if (cnt3) begin
                        if (type_new == TYPE_IEND) begin
                            if (field_shift_reg != 32'd0) begin
                                give_en     = 1'b1;
                                give_status = ST_IEND_LEN;
                            end else begin
                                phase_next = PH_IEND_CRC;
                            end
                        end else if (field_shift_reg == 32'd0) begin
                            phase_next = PH_CH_CRC;
                        end else begin
                            byte_count_next = field_shift_reg[30:0];
                            phase_next      = PH_CH_DATA;
                        end
                    end
                end
                PH_CH_DATA: begin
                    running_crc_next = crc_upd;
                    byte_count_next  = cnt_dec;
                    if (cnt_dec == 31'd0) begin
                        phase_next = PH_CH_CRC;
                    end
                end
                PH_IEND_CRC: begin
                    field_shift_next = fs_new;
                    byte_count_next  = cnt3 ? 31'd0 : cnt_inc;
                    if (cnt3) begin
                        give_en     = 1'b1;
                        give_status = (fs_new == ~running_crc_reg) ? ST_OK : ST_CRC;
                    end
                end
                default: begin
                end
            endcase
            if (give_en) begin
                phase_next         = PH_DONE;
                verdict_given_next = 1'b1;
            end
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end

        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        if (proceed && give_en) begin
            out_valid_next             = 1'b1;
            out_data_next.status       = give_status;
            out_data_next.image_width  = (give_status == ST_OK) ? saved_width_reg : 31'd0;
            out_data_next.image_height = (give_status == ST_OK) ? saved_height_reg : 31'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            phase_reg         <= PH_SIG;
            byte_count_reg    <= '0;
            running_crc_reg   <= CRC_PRESET;
            field_shift_reg   <= '0;
            current_type_reg  <= '0;
            saved_width_reg   <= '0;
            saved_height_reg  <= '0;
            verdict_given_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proceed) begin
                phase_reg         <= phase_next;
                byte_count_reg    <= byte_count_next;
                running_crc_reg   <= running_crc_next;
                field_shift_reg   <= field_shift_next;
                current_type_reg  <= current_type_next;
                saved_width_reg   <= saved_width_next;
                saved_height_reg  <= saved_height_next;
                verdict_given_reg <= verdict_given_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        out_data_reg <= out_data_next;
    end

    a_verdict_done: assert property (@(posedge aclk) disable iff (!aresetn)
        verdict_given_reg == (phase_reg == PH_DONE))
        else $error("verdict flag and done phase disagree");

    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg))
        else $error("phase register not one-hot");

    a_ok_has_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_OK) |->
            (m_data.image_width != 31'd0 && m_data.image_height != 31'd0))
        else $error("ok verdict with zero size");

    a_fail_no_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_OK) |->
            (m_data.image_width == 31'd0 && m_data.image_height == 31'd0))
        else $error("failed verdict carries a size");

    a_end_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        (proceed && in_data_reg.end_mark) |=> (phase_reg == PH_SIG && !verdict_given_reg))
        else $error("end mark did not rearm the parser");

endmodule
